// ===== rtl/core/cdqd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdqd_pkg: shared constants and types
// Sizes, command and status codes, CIGAR characters and the structs passed
// between the sequencer and the base pipeline.
// ----------------------------------------------------------------------------
package cdqd_pkg;

  localparam int NUM_QUANT      = 16;
  localparam int CODEBOOK_DEPTH = 16;
  localparam int MAP_DEPTH      = 4096;
  localparam int STREAM_DEPTH   = 4096;
  localparam int MAX_RUN        = 64;

  localparam int QW    = (NUM_QUANT > 1) ? $clog2(NUM_QUANT) : 1;
  localparam int CB_AW = $clog2(CODEBOOK_DEPTH);
  localparam int MAP_AW = $clog2(MAP_DEPTH);
  localparam int SA_W  = $clog2(STREAM_DEPTH);
  localparam int RUN_W = $clog2(MAX_RUN + 2);
  localparam int RADIX = 10;

  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_M  = 8'h4d;
  localparam logic [7:0] CH_EQ = 8'h3d;
  localparam logic [7:0] CH_X  = 8'h58;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_N  = 8'h4e;
  localparam logic [7:0] CH_H  = 8'h48;
  localparam logic [7:0] CH_P  = 8'h50;

  typedef enum logic [2:0] {
    CMD_CB_LOAD  = 3'd0,
    CMD_MAP_LOAD = 3'd1,
    CMD_STEP_APP = 3'd2,
    CMD_START    = 3'd3,
    CMD_CIGAR    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_OP      = 3'd1,
    ST_RUN_LONG    = 3'd2,
    ST_QUANT_RANGE = 3'd3,
    ST_POS_RANGE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_POS_OFFSET  = 2'd0,
    REG_QUAL_OFFSET = 2'd1,
    REG_QUANT_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_t;

  // one base (or one error result) entering the pipeline
  typedef struct packed {
    logic              valid;
    logic              ins;
    logic              last;
    status_t           status;
    logic [MAP_AW-1:0] addr;
  } issue_t;

  typedef struct packed {
    logic       cb_we;
    logic       map_we;
    logic       stream_we;
    logic [3:0] quantizer;
    logic [3:0] entry_index;
    logic [7:0] recon_value;
    logic [11:0] map_position;
    logic [3:0] symbol;
  } load_t;

  typedef struct packed {
    logic [7:0] qoff;
    logic [4:0] nq;
    logic [3:0] nq_last;
  } ctl_t;

  typedef struct packed {
    logic    valid;
    logic    ins;
    logic    last;
    status_t status;
    logic [3:0] q;
    logic    sym_bad;
  } stage_t;

endpackage

// ===== rtl/core/cdqd_base_pipe.sv =====
// ----------------------------------------------------------------------------
// cdqd_base_pipe: store loads and per-base lookup pipeline
// Holds the quantizer map, step streams and codebooks; one base per cycle
// goes map -> stream -> codebook, with stream read pointers in flops.
// ----------------------------------------------------------------------------
module cdqd_base_pipe (
  input  logic             clk,
  input  logic             rst,
  input  cdqd_pkg::load_t  load,
  input  cdqd_pkg::issue_t issue,
  input  cdqd_pkg::ctl_t   ctl,
  output logic             pipe_busy,
  output logic             result_valid,
  output logic [7:0]       quality,
  output logic             last,
  output logic [2:0]       status
);

  localparam int CB_ENTRIES = cdqd_pkg::NUM_QUANT * cdqd_pkg::CODEBOOK_DEPTH;
  localparam int ST_ENTRIES = cdqd_pkg::NUM_QUANT * cdqd_pkg::STREAM_DEPTH;

  logic [7:0] cb_mem [CB_ENTRIES];
  logic [3:0] map_mem [cdqd_pkg::MAP_DEPTH];
  logic [3:0] stream_mem [ST_ENTRIES];

  logic [cdqd_pkg::SA_W:0]   wptr [cdqd_pkg::NUM_QUANT];
  logic [cdqd_pkg::SA_W-1:0] rptr [cdqd_pkg::NUM_QUANT];

  logic [3:0] map_rd;
  logic [3:0] stream_rd;
  logic [7:0] cb_rd;

  cdqd_pkg::stage_t s1, s2, s3;
  cdqd_pkg::stage_t s2_next, s3_next;

  logic        cb_ok, map_ok, app_ok;
  logic [31:0] mp_ext;
  logic [cdqd_pkg::QW-1:0] ld_q;
  logic        rd_en;
  logic [cdqd_pkg::QW-1:0] rd_q;

  // load address checks
  always_comb begin
    mp_ext = 32'(load.map_position);
    ld_q   = load.quantizer[cdqd_pkg::QW-1:0];
    cb_ok  = load.cb_we && (5'(load.quantizer) < 5'(cdqd_pkg::NUM_QUANT)) &&
             (5'(load.entry_index) < 5'(cdqd_pkg::CODEBOOK_DEPTH));
    map_ok = load.map_we && (mp_ext < 32'(cdqd_pkg::MAP_DEPTH));
    app_ok = load.stream_we && (5'(load.quantizer) < 5'(cdqd_pkg::NUM_QUANT)) &&
             !wptr[ld_q][cdqd_pkg::SA_W];
  end

  always_ff @(posedge clk) begin
    if (cb_ok) begin
      cb_mem[{ld_q, load.entry_index[cdqd_pkg::CB_AW-1:0]}] <= load.recon_value;
    end
  end

  always_ff @(posedge clk) begin
    if (map_ok) begin
      map_mem[mp_ext[cdqd_pkg::MAP_AW-1:0]] <= load.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (app_ok) begin
      stream_mem[{ld_q, wptr[ld_q][cdqd_pkg::SA_W-1:0]}] <= load.symbol;
    end
  end

  // stage 1: quantizer choice and range check, stream read
  always_comb begin
    s2_next   = s1;
    s2_next.q = s1.ins ? ctl.nq_last : map_rd;
    if (s1.status == cdqd_pkg::ST_OK && !s1.ins && ({1'b0, map_rd} >= ctl.nq)) begin
      s2_next.status = cdqd_pkg::ST_QUANT_RANGE;
    end
    rd_en = s1.valid && (s2_next.status == cdqd_pkg::ST_OK);
    rd_q  = s2_next.q[cdqd_pkg::QW-1:0];
  end

  // stage 2: codebook read; symbols past the codebook give zero
  always_comb begin
    s3_next         = s2;
    s3_next.sym_bad = 5'(stream_rd) >= 5'(cdqd_pkg::CODEBOOK_DEPTH);
  end

  always_ff @(posedge clk) begin
    map_rd <= map_mem[issue.addr];
    if (rd_en) begin
      stream_rd <= stream_mem[{rd_q, rptr[rd_q]}];
    end
    cb_rd <= cb_mem[{s2.q[cdqd_pkg::QW-1:0], stream_rd[cdqd_pkg::CB_AW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      for (int i = 0; i < cdqd_pkg::NUM_QUANT; i++) begin
        wptr[i] <= '0;
        rptr[i] <= '0;
      end
    end else begin
      s1 <= '{valid: issue.valid, ins: issue.ins, last: issue.last,
              status: issue.status, q: 4'd0, sym_bad: 1'b0};
      s2 <= s2_next;
      s3 <= s3_next;
      if (app_ok) begin
        wptr[ld_q] <= wptr[ld_q] + {{cdqd_pkg::SA_W{1'b0}}, 1'b1};
      end
      if (rd_en) begin
        rptr[rd_q] <= rptr[rd_q] + cdqd_pkg::SA_W'(1);
      end
    end
  end

  always_comb begin
    pipe_busy    = s1.valid || s2.valid || s3.valid;
    result_valid = s3.valid;
    last         = s3.last;
    status       = s3.status;
    if (s3.status == cdqd_pkg::ST_OK) begin
      quality = (s3.sym_bad ? 8'd0 : cb_rd) + ctl.qoff;
    end else begin
      quality = 8'd0;
    end
  end

endmodule

// ===== rtl/core/cigar_driven_quality_dequantizer_unit.sv =====
// ----------------------------------------------------------------------------
// cigar_driven_quality_dequantizer_unit: CIGAR driven quality decoder
// Loads the quality stores, tracks the genome position and run length, and
// walks each CIGAR operation base by base through the lookup pipeline.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   request   start / busy         cmd quantizer entry_index recon_value
//                                  map_position symbol read_start cigar_char
//   config    wr_en                wr_index wr_data
//   result    result_valid strobe  quality last status
//
// An M/=/X/I/S letter with run n issues one base per cycle for n bases
// after the accept; results pass through the map, stream and codebook
// memories in series, and busy stays high until the last result is out.
// An error result passes through the same memories after the accept,
// with busy high until it is out.
// Synchronous reset clears pointers and control; memories are not cleared.
// Results are strobed for one cycle and cannot be stalled.
module cigar_driven_quality_dequantizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [3:0]  quantizer,
  input  logic [3:0]  entry_index,
  input  logic [7:0]  recon_value,
  input  logic [11:0] map_position,
  input  logic [3:0]  symbol,
  input  logic [31:0] read_start,
  input  logic [7:0]  cigar_char,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  output logic        result_valid,
  output logic [7:0]  quality,
  output logic        last,
  output logic [2:0]  status
);

  localparam logic [cdqd_pkg::RUN_W-1:0] RUN_SAT = cdqd_pkg::RUN_W'(cdqd_pkg::MAX_RUN + 1);
  localparam logic [cdqd_pkg::RUN_W-1:0] RUN_MAX = cdqd_pkg::RUN_W'(cdqd_pkg::MAX_RUN);

  cdqd_pkg::state_t state, state_next;

  logic [31:0] position_offset;
  logic [7:0]  quality_offset;
  logic [4:0]  quantizer_count;

  logic [31:0] position, position_next;
  logic [cdqd_pkg::RUN_W-1:0] run_length, run_length_next;
  logic [cdqd_pkg::RUN_W-1:0] count, count_next;
  logic        mode_ins, mode_ins_next;

  logic        accept, pipe_busy;
  logic        is_cigar, is_digit, is_match, is_ins, is_skip, is_nop, is_op;
  logic        run_long, run_go;
  logic [9:0]  digit_acc;

  cdqd_pkg::issue_t issue;
  cdqd_pkg::load_t  load;
  cdqd_pkg::ctl_t   ctl;

  always_comb begin
    accept   = start && !busy;
    is_cigar = cmd == cdqd_pkg::CMD_CIGAR;
    is_digit = (cigar_char >= cdqd_pkg::CH_0) && (cigar_char <= cdqd_pkg::CH_9);
    is_match = (cigar_char == cdqd_pkg::CH_M) || (cigar_char == cdqd_pkg::CH_EQ) ||
               (cigar_char == cdqd_pkg::CH_X);
    is_ins   = (cigar_char == cdqd_pkg::CH_I) || (cigar_char == cdqd_pkg::CH_S);
    is_skip  = (cigar_char == cdqd_pkg::CH_D) || (cigar_char == cdqd_pkg::CH_N);
    is_nop   = (cigar_char == cdqd_pkg::CH_H) || (cigar_char == cdqd_pkg::CH_P);
    is_op    = is_match || is_ins || is_skip || is_nop;
    run_long = run_length > RUN_MAX;
    run_go   = accept && is_cigar && !is_digit && is_op && !run_long &&
               (is_match || is_ins) && (run_length != '0);
    digit_acc = 10'(run_length) * 10'(cdqd_pkg::RADIX) + 10'(cigar_char[3:0]);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cdqd_pkg::S_IDLE: if (run_go) state_next = cdqd_pkg::S_RUN;
      cdqd_pkg::S_RUN:  if (count == cdqd_pkg::RUN_W'(1)) state_next = cdqd_pkg::S_IDLE;
      default:          state_next = cdqd_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    position_next   = position;
    run_length_next = run_length;
    count_next      = count;
    mode_ins_next   = mode_ins;
    issue           = '0;
    issue.addr      = position[cdqd_pkg::MAP_AW-1:0];
    case (state)
      cdqd_pkg::S_IDLE: begin
        if (accept && cmd == cdqd_pkg::CMD_START) begin
          position_next   = read_start - position_offset;
          run_length_next = '0;
        end else if (accept && is_cigar) begin
          if (is_digit) begin
            run_length_next = (digit_acc > 10'(RUN_SAT)) ? RUN_SAT :
                              digit_acc[cdqd_pkg::RUN_W-1:0];
          end else begin
            run_length_next = '0;
            if (!is_op) begin
              issue.valid  = 1'b1;
              issue.last   = 1'b1;
              issue.status = cdqd_pkg::ST_BAD_OP;
            end else if (run_long) begin
              issue.valid  = 1'b1;
              issue.last   = 1'b1;
              issue.status = cdqd_pkg::ST_RUN_LONG;
            end else if (is_skip) begin
              position_next = position + 32'(run_length);
            end
            count_next    = run_length;
            mode_ins_next = is_ins;
          end
        end
      end
      cdqd_pkg::S_RUN: begin
        issue.valid = 1'b1;
        issue.ins   = mode_ins;
        issue.last  = count == cdqd_pkg::RUN_W'(1);
        count_next  = count - cdqd_pkg::RUN_W'(1);
        if (!mode_ins) begin
          position_next = position + 32'd1;
          if (position >= 32'(cdqd_pkg::MAP_DEPTH)) begin
            issue.status = cdqd_pkg::ST_POS_RANGE;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    load.cb_we        = accept && cmd == cdqd_pkg::CMD_CB_LOAD;
    load.map_we       = accept && cmd == cdqd_pkg::CMD_MAP_LOAD;
    load.stream_we    = accept && cmd == cdqd_pkg::CMD_STEP_APP;
    load.quantizer    = quantizer;
    load.entry_index  = entry_index;
    load.recon_value  = recon_value;
    load.map_position = map_position;
    load.symbol       = symbol;

    ctl.qoff = quality_offset;
    if (quantizer_count == 5'd0) begin
      ctl.nq = 5'd1;
    end else if (quantizer_count > 5'(cdqd_pkg::NUM_QUANT)) begin
      ctl.nq = 5'(cdqd_pkg::NUM_QUANT);
    end else begin
      ctl.nq = quantizer_count;
    end
    ctl.nq_last = 4'(ctl.nq - 5'd1);

    busy = (state == cdqd_pkg::S_RUN) || pipe_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= cdqd_pkg::S_IDLE;
      position        <= '0;
      run_length      <= '0;
      count           <= '0;
      mode_ins        <= 1'b0;
      position_offset <= '0;
      quality_offset  <= 8'd33;
      quantizer_count <= 5'd1;
    end else begin
      state      <= state_next;
      position   <= position_next;
      run_length <= run_length_next;
      count      <= count_next;
      mode_ins   <= mode_ins_next;
      if (wr_en) begin
        case (wr_index)
          cdqd_pkg::REG_POS_OFFSET:  position_offset <= wr_data;
          cdqd_pkg::REG_QUAL_OFFSET: quality_offset  <= wr_data[7:0];
          cdqd_pkg::REG_QUANT_COUNT: quantizer_count <= wr_data[4:0];
          default: ;
        endcase
      end
    end
  end

  cdqd_base_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .issue        (issue),
    .ctl          (ctl),
    .pipe_busy    (pipe_busy),
    .result_valid (result_valid),
    .quality      (quality),
    .last         (last),
    .status       (status)
  );

endmodule

// ===== tb/sv/tb_cigar_driven_quality_dequantizer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_cigar_driven_quality_dequantizer_unit: self-checking bench
// Fills the codebooks, map and step streams on demand, then runs directed and
// random reads of CIGAR operations under several register settings. A
// behavioral copy of the decoder predicts every quality result, and each
// strobed result is checked in order.
// ----------------------------------------------------------------------------
module tb_cigar_driven_quality_dequantizer_unit;
  import cdqd_pkg::*;

  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 95;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  quantizer;
    logic [3:0]  entry_index;
    logic [7:0]  recon_value;
    logic [11:0] map_position;
    logic [3:0]  symbol;
    logic [31:0] read_start;
    logic [7:0]  cigar_char;
  } request_t;

  typedef struct packed {
    logic [7:0] quality;
    logic       lst;
    status_t    status;
  } qual_result_t;

  class quality_checker;
    logic [7:0]  cb_value [NUM_QUANT][CODEBOOK_DEPTH];
    bit          cb_written [NUM_QUANT][CODEBOOK_DEPTH];
    logic [3:0]  qmap [MAP_DEPTH];
    bit          map_written [MAP_DEPTH];
    logic [3:0]  steps [NUM_QUANT][STREAM_DEPTH];
    bit          step_written [NUM_QUANT][STREAM_DEPTH];
    int unsigned step_wr [NUM_QUANT];
    int unsigned step_rd [NUM_QUANT];
    bit [31:0]   pos_ptr;
    int unsigned run_len;
    bit [31:0]   pos_offset;
    bit [7:0]    qual_offset;
    bit [4:0]    quant_count;
    qual_result_t expected_quals[$];
    int          fail_count;

    function new();
      pos_ptr = 0;
      run_len = 0;
      pos_offset = 0;
      qual_offset = 8'd33;
      quant_count = 5'd1;
      fail_count = 0;
      foreach (step_wr[i]) begin
        step_wr[i] = 0;
        step_rd[i] = 0;
      end
    endfunction

    function int unsigned quants_in_use();
      if (quant_count == 0) return 1;
      if (quant_count > NUM_QUANT) return NUM_QUANT;
      return quant_count;
    endfunction

    function bit is_op(logic [7:0] ch);
      return ch == CH_M || ch == CH_EQ || ch == CH_X || ch == CH_I || ch == CH_S ||
             ch == CH_D || ch == CH_N || ch == CH_H || ch == CH_P;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_POS_OFFSET:  pos_offset = d;
        REG_QUAL_OFFSET: qual_offset = d[7:0];
        REG_QUANT_COUNT: quant_count = d[4:0];
        default: ;
      endcase
    endfunction

    function void add_quality(logic [7:0] q, logic l, status_t s);
      qual_result_t e;
      e.quality = q;
      e.lst = l;
      e.status = s;
      expected_quals.insert(expected_quals.size(), e);
    endfunction

    // pops the next step symbol of quantizer q and reconstructs it
    function logic [7:0] next_quality(int unsigned q);
      int unsigned rp;
      logic [3:0] s;
      logic [7:0] v;
      rp = step_rd[q];
      s = steps[q][rp];
      step_rd[q] = (rp + 1) % STREAM_DEPTH;
      v = cb_value[q][s] + qual_offset;
      return v;
    endfunction

    function void decode_cigar(logic [7:0] ch);
      int unsigned n;
      int unsigned nq;
      bit [31:0] pos;
      logic [3:0] q;
      logic lst;
      if (ch >= CH_0 && ch <= CH_9) begin
        run_len = run_len * RADIX + (ch - CH_0);
        if (run_len > MAX_RUN + 1) run_len = MAX_RUN + 1;
        return;
      end
      n = run_len;
      run_len = 0;
      if (!is_op(ch)) begin
        add_quality(8'd0, 1'b1, ST_BAD_OP);
        return;
      end
      if (n > MAX_RUN) begin
        add_quality(8'd0, 1'b1, ST_RUN_LONG);
        return;
      end
      nq = quants_in_use();
      if (ch == CH_M || ch == CH_EQ || ch == CH_X) begin
        for (int unsigned i = 0; i < n; i++) begin
          pos = pos_ptr;
          pos_ptr = pos + 1;
          lst = (i + 1 == n);
          if (pos >= MAP_DEPTH) begin
            add_quality(8'd0, lst, ST_POS_RANGE);
          end else begin
            q = qmap[pos[11:0]];
            if (q >= nq) add_quality(8'd0, lst, ST_QUANT_RANGE);
            else add_quality(next_quality(q), lst, ST_OK);
          end
        end
      end else if (ch == CH_I || ch == CH_S) begin
        for (int unsigned i = 0; i < n; i++)
          add_quality(next_quality(nq - 1), i + 1 == n, ST_OK);
      end else if (ch == CH_D || ch == CH_N) begin
        pos_ptr = pos_ptr + n;
      end
    endfunction

    function void accept_request(request_t r);
      case (r.cmd)
        CMD_CB_LOAD: begin
          cb_value[r.quantizer][r.entry_index] = r.recon_value;
          cb_written[r.quantizer][r.entry_index] = 1'b1;
        end
        CMD_MAP_LOAD: begin
          qmap[r.map_position] = r.symbol;
          map_written[r.map_position] = 1'b1;
        end
        CMD_STEP_APP: begin
          if (step_wr[r.quantizer] < STREAM_DEPTH) begin
            steps[r.quantizer][step_wr[r.quantizer]] = r.symbol;
            step_written[r.quantizer][step_wr[r.quantizer]] = 1'b1;
            step_wr[r.quantizer]++;
          end
        end
        CMD_START: begin
          pos_ptr = r.read_start - pos_offset;
          run_len = 0;
        end
        CMD_CIGAR: decode_cigar(r.cigar_char);
        default: ;
      endcase
    endfunction

    function void check_quality(logic [7:0] q, logic l, logic [2:0] s);
      qual_result_t e;
      if (expected_quals.size() == 0) begin
        $display("%0t: unexpected result quality=%0d last=%0d status=%0d",
                 $time, q, l, s);
        fail_count++;
        return;
      end
      e = expected_quals.pop_front();
      if (q !== e.quality) begin
        $display("%0t: quality mismatch expected %0d actual %0d", $time, e.quality, q);
        fail_count++;
      end
      if (l !== e.lst) begin
        $display("%0t: last mismatch expected %0d actual %0d", $time, e.lst, l);
        fail_count++;
      end
      if (s !== e.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, s);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_quals.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  cmd;
  logic [3:0]  quantizer;
  logic [3:0]  entry_index;
  logic [7:0]  recon_value;
  logic [11:0] map_position;
  logic [3:0]  symbol;
  logic [31:0] read_start;
  logic [7:0]  cigar_char;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;
  logic        result_valid;
  logic [7:0]  quality;
  logic        last;
  logic [2:0]  status;

  quality_checker qchk;
  int quiet_cycles = 0;
  int req_items = 0;
  int no_gap_left = 0;

  cigar_driven_quality_dequantizer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .quantizer    (quantizer),
    .entry_index  (entry_index),
    .recon_value  (recon_value),
    .map_position (map_position),
    .symbol       (symbol),
    .read_start   (read_start),
    .cigar_char   (cigar_char),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .result_valid (result_valid),
    .quality      (quality),
    .last         (last),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) qchk.check_quality(quality, last, status);
  end

  always @(posedge clk) begin
    if ((start && !busy) || result_valid || wr_en) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("cigar_driven_quality_dequantizer_unit test failed");
    $finish;
  end

  // bursts of back-to-back requests between stretches of random gaps
  function automatic int draw_gap();
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      no_gap_left = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic request_t rand_fields(logic [2:0] c);
    request_t r;
    r.cmd = c;
    r.quantizer = 4'($urandom);
    r.entry_index = 4'($urandom);
    r.recon_value = 8'($urandom);
    r.map_position = 12'($urandom);
    r.symbol = 4'($urandom);
    r.read_start = $urandom;
    r.cigar_char = 8'($urandom);
    return r;
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] ch;
    do ch = 8'($urandom);
    while ((ch >= CH_0 && ch <= CH_9) || qchk.is_op(ch));
    return ch;
  endfunction

  task automatic send_req(request_t r);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd = r.cmd;
    quantizer = r.quantizer;
    entry_index = r.entry_index;
    recon_value = r.recon_value;
    map_position = r.map_position;
    symbol = r.symbol;
    read_start = r.read_start;
    cigar_char = r.cigar_char;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    qchk.accept_request(r);
    req_items++;
  endtask

  task automatic send_cigar(logic [7:0] ch);
    request_t r;
    r = rand_fields(CMD_CIGAR);
    r.cigar_char = ch;
    send_req(r);
  endtask

  task automatic load_cb(logic [3:0] q, logic [3:0] e, logic [7:0] v);
    request_t r;
    r = rand_fields(CMD_CB_LOAD);
    r.quantizer = q;
    r.entry_index = e;
    r.recon_value = v;
    send_req(r);
  endtask

  task automatic load_map(logic [11:0] p, logic [3:0] s);
    request_t r;
    r = rand_fields(CMD_MAP_LOAD);
    r.map_position = p;
    r.symbol = s;
    send_req(r);
  endtask

  // codebook entry is loaded first so the symbol never reads an empty slot
  task automatic append_step(logic [3:0] q, logic [3:0] s);
    request_t r;
    if (!qchk.cb_written[q][s]) load_cb(q, s, 8'($urandom));
    r = rand_fields(CMD_STEP_APP);
    r.quantizer = q;
    r.symbol = s;
    send_req(r);
  endtask

  task automatic start_read(bit [31:0] pos);
    request_t r;
    r = rand_fields(CMD_START);
    r.read_start = pos + qchk.pos_offset;
    send_req(r);
  endtask

  task automatic ensure_stream(logic [3:0] q, int unsigned c);
    int unsigned idx;
    for (int unsigned k = 0; k < c; k++) begin
      idx = (qchk.step_rd[q] + k) % STREAM_DEPTH;
      while (!qchk.step_written[q][idx]) append_step(q, 4'($urandom));
    end
  endtask

  // loads whatever map and stream entries the next n bases will read
  task automatic ensure_reads(logic [7:0] op, int unsigned n);
    int unsigned counts [NUM_QUANT];
    int unsigned nq;
    bit [31:0] p;
    logic [3:0] q;
    nq = qchk.quants_in_use();
    foreach (counts[i]) counts[i] = 0;
    if (op == CH_I || op == CH_S) begin
      counts[nq - 1] = n;
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        p = qchk.pos_ptr + i;
        if (p < MAP_DEPTH) begin
          if (!qchk.map_written[p[11:0]])
            load_map(p[11:0], 4'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(0, nq - 1)));
          q = qchk.qmap[p[11:0]];
          if (q < nq) counts[q]++;
        end
      end
    end
    for (int k = 0; k < NUM_QUANT; k++) ensure_stream(4'(k), counts[k]);
  endtask

  task automatic run_op(logic [7:0] op, int unsigned n, bit pad);
    string txt;
    int unsigned eff;
    if (n != 0 || pad) begin
      txt = $sformatf("%0d", n);
      if (pad) txt = {"0", txt};
      for (int i = 0; i < txt.len(); i++) send_cigar(txt[i]);
    end
    eff = qchk.run_len;
    if (eff <= MAX_RUN && (op == CH_M || op == CH_EQ || op == CH_X || op == CH_I ||
                           op == CH_S))
      ensure_reads(op, eff);
    send_cigar(op);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = d;
    @(negedge clk);
    wr_en = 1'b0;
    qchk.write_reg(idx, d);
  endtask

  task automatic set_config(logic [31:0] off, logic [7:0] qoff, logic [4:0] cnt);
    write_reg(REG_POS_OFFSET, off);
    write_reg(REG_QUAL_OFFSET, {24'd0, qoff});
    write_reg(REG_QUANT_COUNT, {27'd0, cnt});
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (qchk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic bit [31:0] pick_pos();
    case ($urandom_range(0, 9))
      6: return $urandom_range(MAP_DEPTH - 36, MAP_DEPTH - 1);
      7: return $urandom;
      8: return 32'hFFFF_FFFF - $urandom_range(0, 20);
      9: return $urandom_range(0, MAP_DEPTH - 1);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int unsigned pick_run();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return ($urandom_range(0, 1) != 0) ? MAX_RUN : $urandom_range(33, MAX_RUN - 1);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  task automatic random_op();
    logic [7:0] base_ops [3];
    logic [7:0] all_ops [9];
    int sel;
    base_ops = '{CH_M, CH_EQ, CH_X};
    all_ops = '{CH_M, CH_EQ, CH_X, CH_I, CH_S, CH_D, CH_N, CH_H, CH_P};
    sel = $urandom_range(0, 99);
    if (sel < 50)
      run_op(base_ops[$urandom_range(0, 2)], pick_run(), $urandom_range(0, 7) == 0);
    else if (sel < 70)
      run_op(($urandom_range(0, 1) != 0) ? CH_I : CH_S, pick_run(), 1'b0);
    else if (sel < 82)
      run_op(($urandom_range(0, 1) != 0) ? CH_D : CH_N, $urandom_range(0, MAX_RUN), 1'b0);
    else if (sel < 87)
      run_op(($urandom_range(0, 1) != 0) ? CH_H : CH_P, $urandom_range(0, 20), 1'b0);
    else if (sel < 94)
      run_op(all_ops[$urandom_range(0, 8)],
             ($urandom_range(0, 3) == 0) ? 99999 : $urandom_range(MAX_RUN + 1, 300), 1'b0);
    else
      run_op(bad_char(), $urandom_range(0, 5), 1'b0);
  endtask

  // stray requests; none of them can read an unloaded entry
  task automatic noise_req();
    logic [7:0] skip_ops [4];
    skip_ops = '{CH_H, CH_P, CH_D, CH_N};
    case ($urandom_range(0, 6))
      0: send_req(rand_fields(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI))));
      1: send_cigar(bad_char());
      2: load_cb(4'($urandom), 4'($urandom), 8'($urandom));
      3: load_map(12'($urandom), 4'($urandom));
      4: append_step(4'($urandom), 4'($urandom));
      5: send_cigar(skip_ops[$urandom_range(0, 3)]);
      default: send_cigar(8'(CH_0 + $urandom_range(0, 9)));
    endcase
  endtask

  task automatic random_phase();
    int target;
    int ops;
    target = req_items + PHASE_ITEMS;
    while (req_items < target) begin
      if ($urandom_range(0, 99) < 70) begin
        start_read(pick_pos());
        ops = $urandom_range(1, 6);
        repeat (ops) begin
          if (req_items < target) random_op();
        end
      end else begin
        noise_req();
      end
    end
  endtask

  task automatic directed();
    send_req(rand_fields(CMD_UNUSED_LO));
    send_req(rand_fields(CMD_UNUSED_HI));
    load_cb(4'd0, 4'd0, 8'hFF);
    load_cb(4'd0, 4'd15, 8'h00);
    load_map(12'd0, 4'd0);
    load_map(12'(MAP_DEPTH - 1), 4'd15);
    append_step(4'd0, 4'd15);
    append_step(4'd0, 4'd0);
    start_read(32'd0);
    run_op(CH_M, 2, 1'b0);
    run_op(CH_H, 0, 1'b0);
    run_op(CH_P, 5, 1'b0);
    run_op(CH_M, 0, 1'b1);
    run_op(CH_I, 1, 1'b0);
    run_op(CH_N, 3, 1'b0);
    run_op(8'h5A, 1, 1'b0);
    send_cigar(8'hFF);
    run_op(CH_X, 99999, 1'b0);
    // quantizer out of range, then off the end of the map
    start_read(32'(MAP_DEPTH - 1));
    run_op(CH_EQ, 2, 1'b0);
    // position wraps from the top of the address space to zero
    start_read(32'hFFFF_FFFF);
    run_op(CH_M, 2, 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_CB_LOAD;
    quantizer = '0;
    entry_index = '0;
    recon_value = '0;
    map_position = '0;
    symbol = '0;
    read_start = '0;
    cigar_char = '0;
    wr_en = 1'b0;
    wr_index = REG_POS_OFFSET;
    wr_data = '0;
    qchk = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed();
    drain();
    set_config(32'd0, 8'd0, 5'd16);
    random_phase();
    drain();
    set_config(32'hFFFF_FFFF, 8'hFF, 5'd0);
    random_phase();
    drain();
    set_config($urandom, 8'($urandom), 5'd31);
    random_phase();
    drain();
    set_config($urandom, 8'($urandom), 5'($urandom_range(1, NUM_QUANT)));
    random_phase();
    drain();

    if (qchk.fail_count == 0 && qchk.pending() == 0) begin
      $display("cigar_driven_quality_dequantizer_unit test passed");
    end else begin
      $display("cigar_driven_quality_dequantizer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cdqd_pkg.sv
rtl/core/cdqd_base_pipe.sv
rtl/core/cigar_driven_quality_dequantizer_unit.sv
tb/sv/tb_cigar_driven_quality_dequantizer_unit.sv
